// File: hdl/fk_pkg.sv
// shared types, constants and fixed-point helpers for the limb kinematics block
package fk_pkg;

  // value types
  typedef logic signed [19:0] q_t;    // q15 trig values and their products
  typedef logic signed [31:0] w_t;    // wide arm terms
  typedef logic signed [35:0] acc_t;  // length times q15 accumulators
  typedef logic signed [32:0] cx_t;   // cordic x and y
  typedef logic signed [31:0] cz_t;   // cordic angle, q28
  typedef logic [11:0] len_t;
  typedef logic signed [13:0] pos_t;
  typedef logic signed [15:0] ang_t;

  localparam int NLANE = 6;
  localparam int CORDIC_STEPS = 18;
  localparam int LANE_LAT = CORDIC_STEPS + 2;
  localparam int MERGE_STAGES = 8;

  typedef q_t qv_t [NLANE];
  typedef q_t q3_t [3];
  typedef acc_t a3_t [3];

  // cordic constants
  localparam cz_t PI_Q28 = 32'sd843314857;
  localparam cz_t HALF_PI_Q28 = 32'sd421657428;
  localparam cz_t QUARTER_PI_Q28 = 32'sd210828714;
  localparam cx_t GAIN_Q30 = 33'sd652032874;
  localparam cz_t ATAN_Q28 [CORDIC_STEPS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
    32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384,
    32'sd8192, 32'sd4096, 32'sd2048
  };
  localparam q_t INV_SQRT2 = 20'sd23170;

  // fixed body points
  localparam len_t SHOULDER_HEIGHT = 12'd1600;
  localparam len_t NECK_HEIGHT = 12'd2024;

  // output range
  localparam acc_t POS_MAX = 36'sd8191;
  localparam acc_t POS_MIN = -36'sd8192;

  // register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_THIGH = 3'd0;
  localparam reg_idx_t REG_TIBIA = 3'd1;
  localparam reg_idx_t REG_FOOT = 3'd2;
  localparam reg_idx_t REG_HIP_Y = 3'd3;
  localparam reg_idx_t REG_HIP_Z = 3'd4;
  localparam reg_idx_t REG_UPPER_ARM = 3'd5;
  localparam reg_idx_t REG_LOWER_ARM = 3'd6;
  localparam reg_idx_t REG_SHOULDER_Y = 3'd7;

  // register reset values
  localparam len_t THIGH_RST = 12'd1600;
  localparam len_t TIBIA_RST = 12'd1646;
  localparam len_t FOOT_RST = 12'd723;
  localparam len_t HIP_Y_RST = 12'd800;
  localparam len_t HIP_Z_RST = 12'd1360;
  localparam len_t UPPER_ARM_RST = 12'd1680;
  localparam len_t LOWER_ARM_RST = 12'd895;
  localparam len_t SHOULDER_Y_RST = 12'd1568;

  // chain selector
  typedef enum logic [2:0] {
    CMD_LEFT_LEG    = 3'd0,
    CMD_RIGHT_LEG   = 3'd1,
    CMD_LEFT_ANKLE  = 3'd2,
    CMD_RIGHT_ANKLE = 3'd3,
    CMD_LEFT_ARM    = 3'd4,
    CMD_RIGHT_ARM   = 3'd5,
    CMD_HEAD        = 3'd6
  } cmd_t;

  typedef struct packed {
    len_t thigh;
    len_t tibia;
    len_t foot;
    len_t hip_y;
    len_t hip_z;
    len_t upper_arm;
    len_t lower_arm;
    len_t shoulder_y;
  } fk_cfg_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fk_ctl_t;

  // q15 by q15, rounded
  function automatic q_t mqq(q_t a, q_t b);
    logic signed [39:0] pr;
    pr = a * b;
    pr = pr + 40'sd16384;
    return q_t'(pr >>> 15);
  endfunction

  // wide by q15, rounded
  function automatic w_t mqw(w_t a, q_t b);
    logic signed [51:0] pr;
    pr = a * b;
    pr = pr + 52'sd16384;
    return w_t'(pr >>> 15);
  endfunction

  // length times q15, exact
  function automatic acc_t lmul(len_t l, q_t b);
    acc_t la;
    acc_t lb;
    la = {24'd0, l};
    lb = b;
    return la * lb;
  endfunction

  // length scaled to q15
  function automatic acc_t lshift(len_t l);
    acc_t r;
    r = {9'd0, l, 15'd0};
    return r;
  endfunction

  // final rounding and saturation
  function automatic pos_t finish(acc_t a);
    acc_t r;
    r = (a + acc_t'(16384)) >>> 15;
    if (r > POS_MAX) r = POS_MAX;
    if (r < POS_MIN) r = POS_MIN;
    return pos_t'(r);
  endfunction

endpackage

// File: hdl/fk_cordic.sv
// pipelined rotation-mode cordic lane giving sine and cosine of one angle
module fk_cordic import fk_pkg::*; (
  input  logic clk,
  input  logic en,
  input  cz_t  z_in,
  output q_t   sin_out,
  output q_t   cos_out
);

  cx_t  x_r   [CORDIC_STEPS+1];
  cx_t  y_r   [CORDIC_STEPS+1];
  cz_t  z_r   [CORDIC_STEPS+1];
  logic neg_r [CORDIC_STEPS+1];
  cz_t  zf;
  logic negf;
  cx_t  xrnd;
  cx_t  yrnd;
  q_t   cos_nxt;
  q_t   sin_nxt;
  q_t   cos_r;
  q_t   sin_r;

  // fold the angle into the half turn around zero
  always_comb begin
    zf = z_in;
    negf = 1'b0;
    if (z_in > HALF_PI_Q28) begin
      zf = z_in - PI_Q28;
      negf = 1'b1;
    end else if (z_in < -HALF_PI_Q28) begin
      zf = z_in + PI_Q28;
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= zf;
      neg_r[0] <= negf;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cx_t xs;
    cx_t ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][31]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ATAN_Q28[i];
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ATAN_Q28[i];
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // round to q15 and undo the fold
  always_comb begin
    xrnd = (x_r[CORDIC_STEPS] + cx_t'(16384)) >>> 15;
    yrnd = (y_r[CORDIC_STEPS] + cx_t'(16384)) >>> 15;
    cos_nxt = q_t'(xrnd);
    sin_nxt = q_t'(yrnd);
    if (neg_r[CORDIC_STEPS]) begin
      cos_nxt = -cos_nxt;
      sin_nxt = -sin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

// File: hdl/fk_merge.sv
// merging pipeline: combines the lane trig values into the chain end position
module fk_merge import fk_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  fk_cfg_t cfg,
  input  fk_ctl_t ctl_in,
  input  qv_t     sn_in,
  input  qv_t     cs_in,
  output fk_ctl_t ctl_out,
  output pos_t    pos_x,
  output pos_t    pos_y,
  output pos_t    pos_z
);

  fk_ctl_t ctl_r [1:MERGE_STAGES];
  qv_t s1_sn_r, s1_cs_r, s2_sn_r, s2_cs_r, s3_sn_r, s3_cs_r;
  qv_t s4_sn_r, s4_cs_r, s5_cs_r;

  // stage 1 products
  q_t m_nxt, cr_nxt, sr_nxt, k_nxt, lx_nxt, a_nxt, b_nxt;
  w_t e_nxt;
  q_t m_r, cr1_r, sr1_r, k_r, lx1_r, a_r, b1_r;
  w_t e_r;

  // stage 2 products
  q_t hcr_nxt, hsr_nxt, px_nxt, qx_nxt, hsk_nxt, hck_nxt;
  q_t bss_nxt, bsc_nxt, spca_nxt, asp_nxt, sps_nxt;
  w_t ec_nxt, es_nxt;
  q_t hcr_r, hsr_r, px_r, qx_r, hsk_r, hck_r, lx2_r, cr2_r, sr2_r;
  q_t bss_r, bsc_r, spca_r, asp_r, sps_r, b2_r;
  w_t ec2_r, es_r;

  // stage 3 terms
  q3_t p_nxt, q_nxt, l_nxt;
  q_t gy, gz;
  acc_t tasp_nxt, tbss_nxt, ay_nxt, tca_nxt;
  w_t ecs_nxt;
  q_t bsps_nxt;
  logic leg_left3, arm_left3;
  q3_t p_r, q_r, l3_r;
  acc_t tasp_r, tbss_r, ay_r, tca_r;
  w_t ecs_r, ec3_r;
  q_t bsps_r;

  // stage 4 terms
  q3_t r1_nxt, r2_nxt;
  a3_t t0_nxt;
  a3_t arm_nxt;
  w_t diff;
  q3_t r1_r, r2_r, l4_r;
  a3_t t0_r, arm4_r;

  // stage 5 terms
  q3_t ia_nxt, ls_nxt;
  a3_t t1_nxt;
  q3_t ia_r, ls_r;
  a3_t t1_r, t0b_r, arm5_r;

  // stage 6 terms
  q3_t inner_nxt;
  a3_t part_nxt;
  acc_t off_y;
  logic leg_left6;
  q3_t inner_r;
  a3_t part_r, arm6_r;

  // stage 7 selection and stage 8 output
  a3_t acc_nxt;
  a3_t acc_r;
  pos_t px8_r, py8_r, pz8_r;

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= MERGE_STAGES; s++) ctl_r[s].valid <= 1'b0;
    end else if (en) begin
      ctl_r[1] <= ctl_in;
      for (int s = 2; s <= MERGE_STAGES; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  // trig values ride along while later stages need them
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sn_r <= sn_in;
      s1_cs_r <= cs_in;
      s2_sn_r <= s1_sn_r;
      s2_cs_r <= s1_cs_r;
      s3_sn_r <= s2_sn_r;
      s3_cs_r <= s2_cs_r;
      s4_sn_r <= s3_sn_r;
      s4_cs_r <= s3_cs_r;
      s5_cs_r <= s4_cs_r;
    end
  end

  // stage 1: hip roll and elbow products
  always_comb begin
    m_nxt = mqq(cs_in[1], sn_in[0]);
    cr_nxt = mqq(cs_in[1], INV_SQRT2);
    sr_nxt = mqq(sn_in[1], INV_SQRT2);
    k_nxt = mqq(sn_in[0], INV_SQRT2);
    lx_nxt = mqq(sn_in[0], sn_in[1]);
    a_nxt = mqq(sn_in[3], sn_in[2]);
    b_nxt = mqq(cs_in[2], sn_in[3]);
    e_nxt = w_t'(lshift(cfg.upper_arm) + lmul(cfg.lower_arm, cs_in[3]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
      cr1_r <= cr_nxt;
      sr1_r <= sr_nxt;
      k_r <= k_nxt;
      lx1_r <= lx_nxt;
      a_r <= a_nxt;
      b1_r <= b_nxt;
      e_r <= e_nxt;
    end
  end

  // stage 2: hip yaw-pitch and shoulder products
  always_comb begin
    hcr_nxt = mqq(s1_cs_r[0], cr1_r);
    hsr_nxt = mqq(s1_cs_r[0], sr1_r);
    px_nxt = mqq(s1_cs_r[0], s1_sn_r[2]) + mqq(s1_cs_r[2], m_r);
    qx_nxt = mqq(s1_cs_r[2], s1_cs_r[0]) - mqq(s1_sn_r[2], m_r);
    hsk_nxt = mqq(s1_sn_r[2], k_r);
    hck_nxt = mqq(s1_cs_r[2], k_r);
    ec_nxt = mqw(e_r, s1_cs_r[1]);
    es_nxt = mqw(e_r, s1_sn_r[1]);
    bss_nxt = mqq(b1_r, s1_sn_r[1]);
    bsc_nxt = mqq(b1_r, s1_cs_r[1]);
    spca_nxt = mqq(s1_cs_r[0], a_r);
    asp_nxt = mqq(a_r, s1_sn_r[0]);
    sps_nxt = mqq(s1_sn_r[0], s1_sn_r[1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hcr_r <= hcr_nxt;
      hsr_r <= hsr_nxt;
      px_r <= px_nxt;
      qx_r <= qx_nxt;
      hsk_r <= hsk_nxt;
      hck_r <= hck_nxt;
      lx2_r <= lx1_r;
      cr2_r <= cr1_r;
      sr2_r <= sr1_r;
      ec2_r <= ec_nxt;
      es_r <= es_nxt;
      bss_r <= bss_nxt;
      bsc_r <= bsc_nxt;
      spca_r <= spca_nxt;
      asp_r <= asp_nxt;
      sps_r <= sps_nxt;
      b2_r <= b1_r;
    end
  end

  // stage 3: thigh direction per axis, arm length terms
  always_comb begin
    leg_left3 = (ctl_r[2].cmd == CMD_LEFT_LEG) || (ctl_r[2].cmd == CMD_LEFT_ANKLE);
    arm_left3 = (ctl_r[2].cmd == CMD_LEFT_ARM);
    p_nxt[0] = px_r;
    q_nxt[0] = qx_r;
    l_nxt[0] = lx2_r;
    if (leg_left3) begin
      gy = hcr_r - sr2_r;
      l_nxt[1] = cr2_r + hsr_r;
      p_nxt[1] = -hsk_r + mqq(s2_cs_r[2], gy);
      q_nxt[1] = -hck_r - mqq(s2_sn_r[2], gy);
      gz = hcr_r + sr2_r;
      l_nxt[2] = hsr_r - cr2_r;
    end else begin
      gy = -hcr_r - sr2_r;
      l_nxt[1] = cr2_r - hsr_r;
      p_nxt[1] = hsk_r + mqq(s2_cs_r[2], gy);
      q_nxt[1] = hck_r - mqq(s2_sn_r[2], gy);
      gz = hcr_r - sr2_r;
      l_nxt[2] = cr2_r + hsr_r;
    end
    p_nxt[2] = -hsk_r + mqq(s2_cs_r[2], gz);
    q_nxt[2] = -hck_r - mqq(s2_sn_r[2], gz);
    tasp_nxt = lmul(cfg.lower_arm, asp_r);
    tbss_nxt = lmul(cfg.lower_arm, bss_r);
    tca_nxt = lmul(cfg.lower_arm, spca_r);
    ecs_nxt = mqw(ec2_r, s2_sn_r[0]);
    bsps_nxt = mqq(b2_r, sps_r);
    ay_nxt = (arm_left3 ? lshift(cfg.shoulder_y) : -lshift(cfg.shoulder_y))
             + lmul(cfg.lower_arm, bsc_r) + acc_t'(es_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
      q_r <= q_nxt;
      l3_r <= l_nxt;
      tasp_r <= tasp_nxt;
      tbss_r <= tbss_nxt;
      tca_r <= tca_nxt;
      ecs_r <= ecs_nxt;
      bsps_r <= bsps_nxt;
      ay_r <= ay_nxt;
      ec3_r <= ec2_r;
    end
  end

  // stage 4: knee rotation, thigh term, arm x and z
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      r1_nxt[j] = mqq(s3_cs_r[3], p_r[j]) + mqq(s3_sn_r[3], q_r[j]);
      r2_nxt[j] = mqq(s3_cs_r[3], q_r[j]) - mqq(s3_sn_r[3], p_r[j]);
      t0_nxt[j] = lmul(cfg.thigh, p_r[j]);
    end
    diff = w_t'(acc_t'(ec3_r) - tbss_r);
    arm_nxt[0] = tasp_r + acc_t'(mqw(diff, s3_cs_r[0]));
    arm_nxt[1] = ay_r;
    arm_nxt[2] = lshift(SHOULDER_HEIGHT) + tca_r - acc_t'(ecs_r)
                 + lmul(cfg.lower_arm, bsps_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
      t0_r <= t0_nxt;
      l4_r <= l3_r;
      arm4_r <= arm_nxt;
    end
  end

  // stage 5: ankle pitch, tibia term
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ia_nxt[j] = mqq(s4_sn_r[4], r2_r[j]) + mqq(s4_cs_r[4], r1_r[j]);
      t1_nxt[j] = lmul(cfg.tibia, r1_r[j]);
      ls_nxt[j] = mqq(s4_sn_r[5], l4_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia_r <= ia_nxt;
      t1_r <= t1_nxt;
      ls_r <= ls_nxt;
      t0b_r <= t0_r;
      arm5_r <= arm4_r;
    end
  end

  // stage 6: ankle roll, hip offsets
  always_comb begin
    leg_left6 = (ctl_r[5].cmd == CMD_LEFT_LEG) || (ctl_r[5].cmd == CMD_LEFT_ANKLE);
    off_y = leg_left6 ? lshift(cfg.hip_y) : -lshift(cfg.hip_y);
    for (int j = 0; j < 3; j++) begin
      inner_nxt[j] = mqq(s5_cs_r[5], ia_r[j]) - ls_r[j];
    end
    part_nxt[0] = -t0b_r[0] - t1_r[0];
    part_nxt[1] = off_y - t0b_r[1] - t1_r[1];
    part_nxt[2] = -lshift(cfg.hip_z) - t0b_r[2] - t1_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inner_r <= inner_nxt;
      part_r <= part_nxt;
      arm6_r <= arm5_r;
    end
  end

  // stage 7: foot term and chain selection
  always_comb begin
    for (int j = 0; j < 3; j++) acc_nxt[j] = '0;
    case (ctl_r[6].cmd)
      CMD_LEFT_LEG, CMD_RIGHT_LEG: begin
        for (int j = 0; j < 3; j++) acc_nxt[j] = part_r[j] - lmul(cfg.foot, inner_r[j]);
      end
      CMD_LEFT_ANKLE, CMD_RIGHT_ANKLE: begin
        for (int j = 0; j < 3; j++) acc_nxt[j] = part_r[j];
      end
      CMD_LEFT_ARM, CMD_RIGHT_ARM: begin
        for (int j = 0; j < 3; j++) acc_nxt[j] = arm6_r[j];
      end
      CMD_HEAD: begin
        acc_nxt[2] = lshift(NECK_HEIGHT);
      end
      default: begin
        for (int j = 0; j < 3; j++) acc_nxt[j] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) acc_r <= acc_nxt;
  end

  // stage 8: round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      px8_r <= finish(acc_r[0]);
      py8_r <= finish(acc_r[1]);
      pz8_r <= finish(acc_r[2]);
    end
  end

  assign ctl_out = ctl_r[MERGE_STAGES];
  assign pos_x = px8_r;
  assign pos_y = py8_r;
  assign pos_z = pz8_r;

endmodule

// File: hdl/humanoid_limb_forward_kinematics.sv
// top level: config registers, six cordic lanes, merge pipeline and output register
//
// Usage:
//   in_*  stream: in_tuser carries the chain selector (left/right leg, left/right
//         ankle, left/right arm, head); in_tdata carries six q3.13 joint angles.
//   out_* stream: out_tdata carries pos_x, pos_y, pos_z, 14 bits each, 1/16 mm,
//         saturated.
//   cfg_* port:   writes one of the eight 12-bit link length registers; write
//         only while no transfer is in flight.
// Throughput is one pose per clock while the pipeline is not held by a stalled result. An
// input transfer passes through the cordic lanes (fold, 18 micro-rotations, rounding),
// the merge pipeline and the output register before it reaches out_tvalid.
// When the receiver stalls, the result is held in the output register and the
// pipeline keeps moving until an item reaches its last stage; only then does
// in_tready drop, so input keeps flowing while a result waits.
// Reset (rst_n low, synchronous) clears all valid flags, drops out_tvalid and
// loads the default link lengths.
module humanoid_limb_forward_kinematics import fk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // joint_angle_0 .. joint_angle_5, 16 bits each
  input  logic [2:0]  in_tuser,   // command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pos_x, pos_y, pos_z, 14 bits each, 6 zero bits
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  len_t        cfg_data
);

  fk_cfg_t cfg_r;
  fk_ctl_t lctl_r [LANE_LAT];
  cz_t     lane_z [NLANE];
  qv_t     lane_sn;
  qv_t     lane_cs;
  fk_ctl_t mctl;
  pos_t    mx, my, mz;
  logic    en;
  logic    out_free;
  logic    out_valid_r;
  logic [47:0] out_data_r;
  cmd_t    in_cmd;
  logic    leg_cmd;
  logic    left_cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thigh <= THIGH_RST;
      cfg_r.tibia <= TIBIA_RST;
      cfg_r.foot <= FOOT_RST;
      cfg_r.hip_y <= HIP_Y_RST;
      cfg_r.hip_z <= HIP_Z_RST;
      cfg_r.upper_arm <= UPPER_ARM_RST;
      cfg_r.lower_arm <= LOWER_ARM_RST;
      cfg_r.shoulder_y <= SHOULDER_Y_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THIGH:      cfg_r.thigh <= cfg_data;
        REG_TIBIA:      cfg_r.tibia <= cfg_data;
        REG_FOOT:       cfg_r.foot <= cfg_data;
        REG_HIP_Y:      cfg_r.hip_y <= cfg_data;
        REG_HIP_Z:      cfg_r.hip_z <= cfg_data;
        REG_UPPER_ARM:  cfg_r.upper_arm <= cfg_data;
        REG_LOWER_ARM:  cfg_r.lower_arm <= cfg_data;
        REG_SHOULDER_Y: cfg_r.shoulder_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: output free or last merge stage empty
  assign out_free = !out_valid_r || out_tready;
  assign en = out_free || !mctl.valid;
  assign in_tready = en;

  // angles to q28, hip roll offset for the legs
  always_comb begin
    in_cmd = cmd_t'(in_tuser);
    leg_cmd = (in_cmd == CMD_LEFT_LEG) || (in_cmd == CMD_RIGHT_LEG)
              || (in_cmd == CMD_LEFT_ANKLE) || (in_cmd == CMD_RIGHT_ANKLE);
    left_cmd = (in_cmd == CMD_LEFT_LEG) || (in_cmd == CMD_LEFT_ANKLE);
    for (int i = 0; i < NLANE; i++) begin
      lane_z[i] = {in_tdata[16*i+15], in_tdata[16*i +: 16], 15'd0};
    end
    if (leg_cmd) begin
      lane_z[1] = left_cmd ? lane_z[1] + QUARTER_PI_Q28 : lane_z[1] - QUARTER_PI_Q28;
    end
  end

  // cordic lanes, one per joint
  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    fk_cordic u_cordic (
      .clk     (clk),
      .en      (en),
      .z_in    (lane_z[i]),
      .sin_out (lane_sn[i]),
      .cos_out (lane_cs[i])
    );
  end

  // control follows the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LANE_LAT; s++) lctl_r[s].valid <= 1'b0;
    end else if (en) begin
      lctl_r[0].valid <= in_tvalid;
      lctl_r[0].cmd <= in_cmd;
      for (int s = 1; s < LANE_LAT; s++) lctl_r[s] <= lctl_r[s-1];
    end
  end

  fk_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .ctl_in  (lctl_r[LANE_LAT-1]),
    .sn_in   (lane_sn),
    .cs_in   (lane_cs),
    .ctl_out (mctl),
    .pos_x   (mx),
    .pos_y   (my),
    .pos_z   (mz)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mctl.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mctl.valid && out_free) begin
      out_data_r <= {6'd0, mz, my, mx};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

// File: hdl/fk_checker.sv
// port-level checks for the limb kinematics block, bound to the top level
module fk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // padding bits are zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:42] == 6'd0)
    else $error("nonzero padding in result");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty output never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

endmodule

bind humanoid_limb_forward_kinematics fk_checker u_fk_checker (.*);
